// File: hw/rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DecW   = 3;
  localparam int unsigned ScaleW = 14;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SegW   = 8;
  localparam int unsigned PosW   = 2;

  localparam logic [DecW-1:0] MaxDecimals = 3'd4;

  // Reciprocal of ten for a 32-bit dividend: (x * Recip10) >> 35 == x / 10.
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } ssd_mode_e;

  // Control that travels with every word through the pipeline.
  typedef struct packed {
    logic            vld;
    ssd_mode_e       mode;
    logic [DecW-1:0] dec;
  } ssd_ctrl_t;

  function automatic logic [ScaleW-1:0] ssd_scale(input logic [DecW-1:0] dec);
    logic [ScaleW-1:0] s;
    unique case (dec)
      3'd0:    s = 14'd1;
      3'd1:    s = 14'd10;
      3'd2:    s = 14'd100;
      3'd3:    s = 14'd1000;
      default: s = 14'd10000;
    endcase
    return s;
  endfunction

  function automatic logic [SegW-1:0] ssd_seg(input logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    unique case (d)
      4'd0:    p = 8'hFC;
      4'd1:    p = 8'h60;
      4'd2:    p = 8'hDA;
      4'd3:    p = 8'hF2;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'hB6;
      4'd6:    p = 8'hBE;
      4'd7:    p = 8'hE0;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hF6;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/seven_segment_scan_display.sv
// Structure: the input register, the scaling multiply, one divide-by-ten stage per digit and
// the output register form a single in-order pipeline that moves as one. Throughput: one
// word per cycle while no finished word is held at the output by out_stall_i.
// Reset clears the pipeline valids, the loaded flag, the scan position and the output
// valid; stored digit patterns are undefined until the first load reaches the end.
module seven_segment_scan_display
  import ssd_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [ValueW-1:0]   value_fixed_i,
  input  logic [DecW-1:0]     decimals_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SegW-1:0]     segments_o,
  output logic [PosW-1:0]     digit_position_o
);

  localparam int unsigned NumStages = NUM_DIGITS + 2;
  localparam int unsigned ScanW     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned ProdW     = ValueW + ScaleW;

  // Stage 0 holds the input word, stage 1 the scaled whole part, stage k+2 the
  // word after digit k has been split off.
  ssd_ctrl_t ctrl_q [NumStages];
  ssd_ctrl_t ctrl_in;

  logic [ValueW-1:0]  value_q;
  logic [ProdW-1:0]   prod;
  logic [ValueW-1:0]  rem_q [NUM_DIGITS];
  logic [DigitW-1:0]  dig_q [NUM_DIGITS][NUM_DIGITS];

  logic [SegW-1:0]    pat_q [NUM_DIGITS];
  logic               loaded_q;
  logic [ScanW-1:0]   scan_q, scan_d;
  logic               out_valid_q;
  logic [SegW-1:0]    segments_q;
  logic [PosW-1:0]    pos_q;
  logic [31:0]        scan_ext;

  logic               adv;
  ssd_ctrl_t          last;
  logic               commit_load;
  logic               commit_tick;

  // The whole pipeline advances unless a finished word sits unaccepted at the output.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    ctrl_in.vld  = in_valid_i;
    ctrl_in.mode = ssd_mode_e'(mode_i);
    ctrl_in.dec  = (decimals_i > MaxDecimals) ? MaxDecimals : decimals_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (adv) begin
      ctrl_q[0] <= ctrl_in;
      for (int i = 1; i < NumStages; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q <= value_fixed_i;
    end
  end

  assign prod = value_q * ssd_scale(ctrl_q[0].dec);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= ValueW'(prod[ProdW-1:16]);
    end
  end

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    logic [2*ValueW-1:0] recip_prod;
    logic [ValueW-1:0]   quot;
    logic [ValueW-1:0]   rem_digit;

    assign recip_prod = {{ValueW{1'b0}}, rem_q[k]} * {{ValueW{1'b0}}, Recip10};
    assign quot       = ValueW'(recip_prod[2*ValueW-1:Recip10Shift]);
    assign rem_digit  = rem_q[k] - ((quot << 3) + (quot << 1));

    if (k + 1 < NUM_DIGITS) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[k+1] <= quot;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int j = 0; j < NUM_DIGITS; j++) begin
          if (j == k) begin
            dig_q[k][j] <= rem_digit[DigitW-1:0];
          end else if (k == 0) begin
            dig_q[k][j] <= '0;
          end else begin
            dig_q[k][j] <= dig_q[k-1][j];
          end
        end
      end
    end
  end

  assign last        = ctrl_q[NumStages-1];
  assign commit_load = adv && last.vld && (last.mode == MODE_LOAD);
  assign commit_tick = adv && last.vld && (last.mode == MODE_TICK) && loaded_q;

  always_ff @(posedge clk_i) begin
    if (commit_load) begin
      for (int j = 0; j < NUM_DIGITS; j++) begin
        pat_q[j] <= ssd_seg(dig_q[NUM_DIGITS-1][j])
                    | {7'd0, (last.dec != '0) && (32'(last.dec) == 32'(j))};
      end
    end
  end

  always_comb begin
    if (32'(scan_q) == NUM_DIGITS - 1) begin
      scan_d = '0;
    end else begin
      scan_d = scan_q + ScanW'(1);
    end
  end

  assign scan_ext = 32'(scan_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= commit_tick;
      if (commit_load) begin
        loaded_q <= 1'b1;
      end
      if (commit_tick) begin
        scan_q <= scan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_tick) begin
      segments_q <= pat_q[scan_q];
      pos_q      <= scan_ext[PosW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segments_o       = segments_q;
  assign digit_position_o = pos_q;

  // A word only reaches the output after some load has committed.
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> loaded_q)
    else $error("result word issued before any load");

  // The scan position stays within the digit count.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_q) < NUM_DIGITS)
    else $error("scan position out of range");

  // The scan position moves only on a committed tick.
  a_scan_moves_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q != $past(scan_q)) |-> $past(commit_tick))
    else $error("scan position moved without a tick");

  // Once loaded, the block stays loaded.
  a_loaded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(loaded_q))
    else $error("loaded flag cleared");

endmodule
